// ----- rtl/core/mpbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mpbs_pkg
// Shared widths, the pattern library and the report type of the byte scanner.
// ----------------------------------------------------------------------------
package mpbs_pkg;

  localparam int HISTORY_BYTES = 28;
  localparam int WIN_BITS      = 8 * HISTORY_BYTES;
  localparam int HIST_BITS     = 8 * (HISTORY_BYTES - 1);
  localparam int PATTERN_COUNT = 13;
  localparam int COUNT_W       = 40;

  localparam int BIT_GL     = 6;
  localparam int BIT_GLES_A = 7;
  localparam int BIT_GLES_B = 8;

  typedef logic [PATTERN_COUNT-1:0] mask_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [WIN_BITS-1:0]      win_t;

  typedef struct packed {
    mask_t  mask;
    count_t count;
  } report_t;

  // Right-aligned pattern text: last character in the low byte.
  localparam win_t PAT_TEXT [PATTERN_COUNT] = '{
    WIN_BITS'("d3d9.dll"),
    WIN_BITS'("d3d11.dll"),
    WIN_BITS'("d3d11createdevice"),
    WIN_BITS'("d3d12.dll"),
    WIN_BITS'("d3d12createdevice"),
    WIN_BITS'("dxgi.dll"),
    WIN_BITS'("opengl32.dll"),
    WIN_BITS'("libglesv2"),
    WIN_BITS'("libegl"),
    WIN_BITS'("vulkan-1.dll"),
    WIN_BITS'("vkcreateinstance"),
    WIN_BITS'(120'h6d6574616c2e6672616d65776f726b),
    WIN_BITS'("mtlcreatesystemdefaultdevice")
  };

  localparam int PAT_LEN [PATTERN_COUNT] = '{
    8, 9, 17, 9, 17, 8, 12, 9, 6, 12, 16, 15, 28
  };

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mpbs_match.sv -----
// ----------------------------------------------------------------------------
// mpbs_match
// Parallel comparators: flags every library pattern that ends at the newest
// byte of the window.
// ----------------------------------------------------------------------------
module mpbs_match
  import mpbs_pkg::*;
(
  input  win_t  win,
  output mask_t hit
);

  for (genvar k = 0; k < PATTERN_COUNT; k++) begin : g_pat
    localparam int L = PAT_LEN[k];
    assign hit[k] = (win[8*L-1:0] == PAT_TEXT[k][8*L-1:0]);
  end

endmodule

// ----- rtl/core/mpbs_scan.sv -----
// ----------------------------------------------------------------------------
// mpbs_scan
// Scan state: byte history, sticky found mask and byte counter, with the
// report formed for the current beat.
// ----------------------------------------------------------------------------
module mpbs_scan
  import mpbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  count_t     byte_limit,
  output report_t    rpt
);

  logic [HIST_BITS-1:0] hist;
  mask_t                seen;
  count_t               counter;

  logic   examine;
  win_t   win;
  mask_t  hit;
  mask_t  seen_next;
  count_t counter_next;
  mask_t  rmask;

  assign examine = (counter < byte_limit);
  assign win     = {hist, fold_case(data_byte)};

  mpbs_match u_match (
    .win (win),
    .hit (hit)
  );

  assign seen_next    = examine ? (seen | hit) : seen;
  assign counter_next = examine ? (counter + count_t'(1)) : counter;

  always_comb begin
    rmask = seen_next;
    if (rmask[BIT_GLES_A] || rmask[BIT_GLES_B]) begin
      rmask[BIT_GL] = 1'b0;
    end
  end

  assign rpt.mask  = rmask;
  assign rpt.count = counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist    <= '0;
      seen    <= '0;
      counter <= '0;
    end else if (step) begin
      if (last_byte) begin
        hist    <= '0;
        seen    <= '0;
        counter <= '0;
      end else begin
        if (examine) begin
          hist <= win[HIST_BITS-1:0];
        end
        seen    <= seen_next;
        counter <= counter_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> counter == '0 && seen == '0)
    else $error("scan state not cleared after last beat");

  a_seen_needs_count: assert property (@(posedge clk) disable iff (rst)
    counter == '0 |-> seen == '0)
    else $error("found bits without examined bytes");

endmodule

// ----- rtl/core/multi_pattern_byte_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_byte_scanner_unit
// Case-insensitive scan of a byte stream for a fixed library of thirteen
// names; one report per stream.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall, one byte a beat (data_byte), last_byte
//   marks the final byte of a stream.
// Output channel: out_valid / out_stall, one beat per stream carrying
//   found_mask and bytes_scanned.
// Config channel: cfg_valid / cfg_ready / cfg_data writes byte_limit; write
//   only while the block is idle. cfg_ready is always high.
// Throughput: one byte per cycle unless a last byte stalls; the history
//   shift and all comparators sit between the input and report registers.
// Report path: a last byte passes the input register, then the report register.
// Stall: a waiting report holds in the output register; plain bytes keep
//   flowing, and a last byte waits in the input register, raising in_stall,
//   until the report register frees.
// Reset: clears scan state and both valid bits; byte_limit returns to all ones.
// ----------------------------------------------------------------------------
module multi_pattern_byte_scanner_unit
  import mpbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output mask_t      found_mask,
  output count_t     bytes_scanned,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  count_t     cfg_data
);

  count_t     byte_limit;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  logic    out_free;
  logic    s1_go;
  logic    accept;
  report_t rpt;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign s1_go     = s1_valid && (!s1_last || out_free);
  assign in_stall  = s1_valid && !s1_go;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= '1;
    end else if (cfg_valid && cfg_ready) begin
      byte_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  mpbs_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_go),
    .data_byte  (s1_byte),
    .last_byte  (s1_last),
    .byte_limit (byte_limit),
    .rpt        (rpt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      found_mask    <= rpt.mask;
      bytes_scanned <= rpt.count;
    end
  end

  a_count_in_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bytes_scanned <= byte_limit)
    else $error("reported count exceeds byte limit");

  a_gl_suppressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && (found_mask[BIT_GLES_A] || found_mask[BIT_GLES_B]) |->
      !found_mask[BIT_GL])
    else $error("desktop GL bit reported alongside GLES");

  a_plain_byte_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_last |-> !in_stall)
    else $error("input stalled behind a plain byte");

  a_report_follows_last: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> out_valid)
    else $error("last beat left no report");

endmodule
